### src/obta_pkg.sv
// Shared types, codes and field layout for the order book transition audit.
package obta_pkg;

   localparam int unsigned PriceWidth = 32;
   localparam int unsigned FlowWidth  = 34;

   localparam int unsigned ReqDataWidth = 320;
   localparam int unsigned ReqUserWidth = 6;
   localparam int unsigned RspDataWidth = 40;
   localparam int unsigned RspUserWidth = 4;

   // Event opcodes.
   localparam logic [3:0] OP_SEED        = 4'd0;
   localparam logic [3:0] OP_SUBMIT      = 4'd1;
   localparam logic [3:0] OP_CANCEL      = 4'd2;
   localparam logic [3:0] OP_DELETE      = 4'd3;
   localparam logic [3:0] OP_VISIBLE_EXE = 4'd4;
   localparam logic [3:0] OP_HIDDEN_EXE  = 4'd5;
   localparam logic [3:0] OP_CROSS       = 4'd6;
   localparam logic [3:0] OP_HALT        = 4'd7;

   // Side codes; anything above the bid code is an unsupported direction.
   localparam logic [1:0] SIDE_ASK = 2'd0;
   localparam logic [1:0] SIDE_BID = 2'd1;

   typedef enum logic [2:0] {
      ST_EXACT       = 3'd0,
      ST_CENSORED    = 3'd1,
      ST_MISMATCH    = 3'd2,
      ST_UNSUPPORTED = 3'd3,
      ST_NOT_AUDITED = 3'd4
   } status_type;

   // Two levels of one side of the book.
   typedef struct packed {
      logic signed [PriceWidth-1:0] p0;
      logic signed [PriceWidth-1:0] s0;
      logic signed [PriceWidth-1:0] p1;
      logic signed [PriceWidth-1:0] s1;
   } side_type;

   typedef struct packed {
      side_type ask;
      side_type bid;
   } book_type;

   typedef struct packed {
      logic [3:0]                   opcode;
      logic [1:0]                   side;
      logic signed [PriceWidth-1:0] order_price;
      logic signed [PriceWidth-1:0] order_size;
      book_type                     snap;
   } item_type;

endpackage

### src/order_book_transition_audit.sv
// Top level of the order book transition audit: channels, registers and state.
//
// Each request item carries one order event and the two-level book snapshot
// that was seen after it. The block compares the snapshot with what the event
// should have done to the previous snapshot and returns one response item per
// request item: the audit status, a flag that the snapshot is well formed,
// and the top-of-book order flow imbalance against the previous snapshot.
//
// Both channels use a valid/ready handshake. A request item passes through
// an input register, the audit logic and a result register; its response
// shows on rsp_tvalid once it has moved into the result register. One item
// is accepted every cycle while the receiver keeps rsp_tready high; the rate
// is set by the single pass of compare logic between those two registers.
//
// When the receiver stalls, the result register holds its item and the
// input register fills up; req_tready then drops until the result is taken.
// The previous snapshot is replaced as each item moves into the result
// register, so items are graded strictly in arrival order.
//
// Reset empties both registers and forgets the previous snapshot, so the
// first item after reset is reported as not audited.
module order_book_transition_audit
   import obta_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   // order_price, order_size, best_ask_price, best_ask_size, second_ask_price,
   // second_ask_size, best_bid_price, best_bid_size, second_bid_price,
   // second_bid_size (32 bits each)
   input  logic [ReqDataWidth-1:0] req_tdata,
   // opcode (4 bits), side (2 bits)
   input  logic [ReqUserWidth-1:0] req_tuser,

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // flow_imbalance (34 bits), zero fill (6 bits)
   output logic [RspDataWidth-1:0] rsp_tdata,
   // audit_status (3 bits), snapshot_ok (1 bit)
   output logic [RspUserWidth-1:0] rsp_tuser
);

   item_type                    req_item;
   logic                        out_free;
   logic                        s1_advance;
   logic                        req_take;

   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   item_type                    s1_item_ff;

   logic                        out_valid_ff;
   logic                        out_valid_in;
   status_type                  out_status_ff;
   logic                        out_ok_ff;
   logic signed [FlowWidth-1:0] out_flow_ff;

   book_type                    prior_ff;
   logic                        have_prior_ff;

   status_type                  calc_status;
   logic                        calc_ok;
   logic signed [FlowWidth-1:0] calc_flow;
   logic                        flow_en;

   // Unpack the request fields from the low bits upward.
   always_comb begin
      req_item.opcode          = req_tuser[3:0];
      req_item.side            = req_tuser[5:4];
      req_item.order_price     = req_tdata[31:0];
      req_item.order_size      = req_tdata[63:32];
      req_item.snap.ask.p0     = req_tdata[95:64];
      req_item.snap.ask.s0     = req_tdata[127:96];
      req_item.snap.ask.p1     = req_tdata[159:128];
      req_item.snap.ask.s1     = req_tdata[191:160];
      req_item.snap.bid.p0     = req_tdata[223:192];
      req_item.snap.bid.s0     = req_tdata[255:224];
      req_item.snap.bid.p1     = req_tdata[287:256];
      req_item.snap.bid.s1     = req_tdata[319:288];
   end

   // The input register moves on whenever the result register is free or
   // is being emptied in the same cycle.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Seeds and the first item after reset carry no imbalance.
   assign flow_en = have_prior_ff && (s1_item_ff.opcode != OP_SEED);

   obta_audit u_audit (
      .item       (s1_item_ff),
      .prior      (prior_ff),
      .have_prior (have_prior_ff),
      .status     (calc_status)
   );

   obta_metrics u_metrics (
      .prior          (prior_ff),
      .snap           (s1_item_ff.snap),
      .flow_en        (flow_en),
      .snapshot_ok    (calc_ok),
      .flow_imbalance (calc_flow)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         have_prior_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_advance) begin
            have_prior_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (s1_advance) begin
         out_status_ff <= calc_status;
         out_ok_ff     <= calc_ok;
         out_flow_ff   <= calc_flow;
         prior_ff      <= s1_item_ff.snap;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-FlowWidth){1'b0}}, out_flow_ff};
   assign rsp_tuser  = {out_ok_ff, out_status_ff};

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_not_audited_no_flow: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == ST_NOT_AUDITED) |-> (out_flow_ff == '0))
      else $error("unaudited item carries a flow imbalance");

   a_prior_sticky: assert property (@(posedge clock) disable iff (reset)
      have_prior_ff |=> have_prior_ff)
      else $error("previous snapshot lost without reset");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while both registers are held");

   a_first_unaudited: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !have_prior_ff) |=> (out_status_ff == ST_NOT_AUDITED))
      else $error("first item after reset was audited");
`endif

endmodule

### src/obta_audit.sv
// Predicts the new book from the prior one and grades the item's snapshot.
module obta_audit
   import obta_pkg::*;
(
   input  item_type   item,
   input  book_type   prior,
   input  logic       have_prior,
   output status_type status
);

   localparam logic signed [PriceWidth:0] MergeMax = 33'sh7FFF_FFFF;

   logic                         bids;
   side_type                     pv_own;
   side_type                     cv_own;
   logic                         own_same;
   logic                         other_same;
   logic                         size_pos;
   logic                         eq0;
   logic                         eq1;
   logic signed [PriceWidth-1:0] sel_size;
   logic signed [PriceWidth:0]   merged;
   logic signed [PriceWidth:0]   left;
   side_type                     merge_pred;
   side_type                     keep_pred;
   side_type                     ins_pred;
   logic                         swap01;
   logic signed [PriceWidth-1:0] a_p;
   logic signed [PriceWidth-1:0] a_s;
   logic signed [PriceWidth-1:0] b_p;
   logic signed [PriceWidth-1:0] b_s;
   logic                         beat_a;
   logic                         beat_b;
   logic                         exposed_ok;
   status_type                   submit_st;
   status_type                   remove_st;

   function automatic logic better(input logic signed [PriceWidth-1:0] x,
                                   input logic signed [PriceWidth-1:0] y,
                                   input logic                         on_bid);
      better = on_bid ? (x > y) : (x < y);
   endfunction

   always_comb begin
      bids       = (item.side == SIDE_BID);
      pv_own     = bids ? prior.bid : prior.ask;
      cv_own     = bids ? item.snap.bid : item.snap.ask;
      own_same   = (pv_own == cv_own);
      other_same = bids ? (prior.ask == item.snap.ask) : (prior.bid == item.snap.bid);
      size_pos   = (item.order_size > 0);

      // The first level with an equal price is the one that matches.
      eq0      = (pv_own.p0 == item.order_price);
      eq1      = (pv_own.p1 == item.order_price);
      sel_size = eq0 ? pv_own.s0 : pv_own.s1;
      merged   = {sel_size[PriceWidth-1], sel_size}
               + {item.order_size[PriceWidth-1], item.order_size};
      left     = {sel_size[PriceWidth-1], sel_size}
               - {item.order_size[PriceWidth-1], item.order_size};

      merge_pred = pv_own;
      keep_pred  = pv_own;
      if (eq0) begin
         merge_pred.s0 = merged[PriceWidth-1:0];
         keep_pred.s0  = left[PriceWidth-1:0];
      end else begin
         merge_pred.s1 = merged[PriceWidth-1:0];
         keep_pred.s1  = left[PriceWidth-1:0];
      end

      // Stable insertion of the new level into the two held levels.
      swap01 = better(pv_own.p1, pv_own.p0, bids);
      a_p    = swap01 ? pv_own.p1 : pv_own.p0;
      a_s    = swap01 ? pv_own.s1 : pv_own.s0;
      b_p    = swap01 ? pv_own.p0 : pv_own.p1;
      b_s    = swap01 ? pv_own.s0 : pv_own.s1;
      beat_b = better(item.order_price, b_p, bids);
      beat_a = better(item.order_price, a_p, bids);
      if (!beat_b) begin
         ins_pred = '{p0: a_p, s0: a_s, p1: b_p, s1: b_s};
      end else if (beat_a) begin
         ins_pred = '{p0: item.order_price, s0: item.order_size, p1: a_p, s1: a_s};
      end else begin
         ins_pred = '{p0: a_p, s0: a_s, p1: item.order_price, s1: item.order_size};
      end

      if (!size_pos || !other_same) begin
         submit_st = ST_MISMATCH;
      end else if (eq0 || eq1) begin
         submit_st = ((merged <= MergeMax) && (merge_pred == cv_own)) ? ST_EXACT
                                                                      : ST_MISMATCH;
      end else begin
         submit_st = (ins_pred == cv_own) ? ST_EXACT : ST_MISMATCH;
      end

      // When a level empties, the other held level must now be on top.
      exposed_ok = eq0 ? (cv_own.p0 == pv_own.p1 && cv_own.s0 == pv_own.s1)
                       : (cv_own.p0 == pv_own.p0 && cv_own.s0 == pv_own.s0);

      if (!size_pos || !other_same) begin
         remove_st = ST_MISMATCH;
      end else if (!eq0 && !eq1) begin
         remove_st = own_same ? ST_EXACT : ST_MISMATCH;
      end else if (left[PriceWidth]) begin
         remove_st = ST_MISMATCH;
      end else if (left != '0) begin
         remove_st = (keep_pred == cv_own) ? ST_EXACT : ST_MISMATCH;
      end else begin
         remove_st = exposed_ok ? ST_CENSORED : ST_MISMATCH;
      end

      if ((item.opcode == OP_SEED) || !have_prior) begin
         status = ST_NOT_AUDITED;
      end else if (item.side > SIDE_BID) begin
         status = ST_UNSUPPORTED;
      end else begin
         case (item.opcode)
            OP_SUBMIT: begin
               status = submit_st;
            end
            OP_CANCEL, OP_DELETE, OP_VISIBLE_EXE: begin
               status = remove_st;
            end
            OP_HIDDEN_EXE, OP_CROSS, OP_HALT: begin
               status = (prior == item.snap) ? ST_EXACT : ST_MISMATCH;
            end
            default: begin
               status = ST_UNSUPPORTED;
            end
         endcase
      end
   end

endmodule

### src/obta_metrics.sv
// Snapshot sanity check and top-of-book order flow imbalance.
module obta_metrics
   import obta_pkg::*;
(
   input  book_type                     prior,
   input  book_type                     snap,
   input  logic                         flow_en,
   output logic                         snapshot_ok,
   output logic signed [FlowWidth-1:0]  flow_imbalance
);

   logic signed [FlowWidth-1:0] bid_add;
   logic signed [FlowWidth-1:0] bid_rem;
   logic signed [FlowWidth-1:0] ask_add;
   logic signed [FlowWidth-1:0] ask_rem;

   function automatic logic signed [FlowWidth-1:0] ext(
      input logic signed [PriceWidth-1:0] v);
      ext = {{(FlowWidth-PriceWidth){v[PriceWidth-1]}}, v};
   endfunction

   always_comb begin
      snapshot_ok = (snap.ask.p0 > 0) && (snap.ask.s0 > 0) && (snap.ask.p1 > 0)
                 && (snap.ask.s1 > 0) && (snap.bid.p0 > 0) && (snap.bid.s0 > 0)
                 && (snap.bid.p1 > 0) && (snap.bid.s1 > 0)
                 && (snap.bid.p0 < snap.ask.p0) && (snap.ask.p0 < snap.ask.p1)
                 && (snap.bid.p0 > snap.bid.p1);

      bid_add = (snap.bid.p0 >= prior.bid.p0) ? ext(snap.bid.s0) : '0;
      bid_rem = (snap.bid.p0 <= prior.bid.p0) ? ext(prior.bid.s0) : '0;
      ask_add = (snap.ask.p0 <= prior.ask.p0) ? ext(snap.ask.s0) : '0;
      ask_rem = (snap.ask.p0 >= prior.ask.p0) ? ext(prior.ask.s0) : '0;

      flow_imbalance = flow_en ? (bid_add - bid_rem - ask_add + ask_rem) : '0;
   end

endmodule
